// ----- src/assert_macros.svh -----
// Assertion macros for the block's RTL, included by the matcher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold in the same cycle as its trigger.
`define ASSERT_SAME(label, clk, rst_n, trig, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error("assertion failed");
// Property that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, trig, prop)
`define ASSERT_NEXT(label, clk, rst_n, trig, prop)
`endif
`endif

// ----- src/hlfm_pkg.sv -----
// Types, constants and helper functions of the header line field matcher.
package hlfm_pkg;

  localparam int STR_BYTES = 16;

  typedef logic [STR_BYTES-1:0][7:0] byte_str_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;

  localparam logic [2:0] CFG_NAME_LOW   = 3'd0;
  localparam logic [2:0] CFG_NAME_HIGH  = 3'd1;
  localparam logic [2:0] CFG_NAME_LEN   = 3'd2;
  localparam logic [2:0] CFG_VALUE_LOW  = 3'd3;
  localparam logic [2:0] CFG_VALUE_HIGH = 3'd4;
  localparam logic [2:0] CFG_VALUE_LEN  = 3'd5;

  typedef enum logic [2:0] {
    PH_NAME  = 3'b001,
    PH_LEAD  = 3'b010,
    PH_VALUE = 3'b100
  } phase_t;

  // Progress of the comparison of one part (name or value) of a line.
  typedef struct packed {
    logic [4:0] pos;
    logic       prefix_mismatch;
    logic       tail_not_blank;
    logic       boundary_blank;
  } part_state_t;

  localparam part_state_t PART_CLEAR = '{pos: 5'd0, prefix_mismatch: 1'b0,
                                         tail_not_blank: 1'b0, boundary_blank: 1'b0};

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'd32) : b;
  endfunction

  // A part matches when its length is within the limit, all expected bytes were
  // seen and agreed, any extra bytes were blank, and the last expected byte was not itself blank.
  function automatic logic part_match(input part_state_t st, input logic [4:0] len,
                                      input logic [4:0] limit);
    logic ok;
    ok = 1'b1;
    if (len > limit) ok = 1'b0;
    if ((st.pos < len) || st.prefix_mismatch || st.tail_not_blank) ok = 1'b0;
    if ((len != 5'd0) && st.boundary_blank) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ----- src/hlfm_part_unit.sv -----
// Per-byte comparison step of one line part against its expected string.
module hlfm_part_unit
  import hlfm_pkg::*;
(
  input  logic [7:0]  data_byte,
  input  part_state_t cur,
  input  logic [4:0]  len,
  input  logic [4:0]  limit,
  input  logic        fold,
  input  byte_str_t   exp_str,
  output part_state_t nxt
);

  logic [7:0] exp_b;
  logic [7:0] act_c;
  logic [7:0] exp_c;

  always_comb begin
    exp_b = exp_str[cur.pos[3:0]];
    act_c = fold ? fold_case(data_byte) : data_byte;
    exp_c = fold ? fold_case(exp_b) : exp_b;
    nxt   = cur;
    if (cur.pos < len) begin
      // Positions past the configured storage can never agree.
      if (!((cur.pos < limit) && !cur.pos[4]) || (act_c != exp_c)) begin
        nxt.prefix_mismatch = 1'b1;
      end
      if ((cur.pos + 5'd1) == len) begin
        nxt.boundary_blank = is_blank(data_byte);
      end
    end else if (!is_blank(data_byte)) begin
      nxt.tail_not_blank = 1'b1;
    end
    if (cur.pos != 5'd31) begin
      nxt.pos = cur.pos + 5'd1;
    end
  end

endmodule

// ----- src/header_line_field_matcher.sv -----
// Header line field matcher: one header byte per word, a found flag per block.
// Each word updates the line state in the cycle it is accepted; a word can be
// accepted in every cycle while the result side is free or being drained.
// The result of a flagged word appears in the cycle after acceptance, set by
// the combinational line state update feeding the output register.
// Synchronous active-low reset clears line state and registers but out_found_r.
`include "assert_macros.svh"
module header_line_field_matcher
  import hlfm_pkg::*;
#(
  parameter int NAME_BYTES      = 16,
  parameter int VALUE_STR_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_header_byte,
  input  logic        in_end_of_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_header_found
);

  localparam logic [4:0] NAME_LIM  = 5'(NAME_BYTES);
  localparam logic [4:0] VALUE_LIM = 5'(VALUE_STR_BYTES);

  logic [NAME_BYTES-1:0][7:0]      exp_name_r;
  logic [VALUE_STR_BYTES-1:0][7:0] exp_value_r;
  logic [4:0]                      name_len_r;
  logic [4:0]                      value_len_r;

  phase_t      phase_r, phase_nxt, ph1;
  part_state_t part_r, part_nxt, part1, part_step;
  logic        nm_r, nm_nxt, nm1;
  logic        found_r, found_nxt, found1;
  logic        out_valid_r;
  logic        out_found_r;
  logic        last_hit;

  byte_str_t  name_pad, value_pad, sel_str;
  logic [4:0] sel_len, sel_limit;
  logic       sel_name;
  logic       in_fire;

  assign cfg_ready        = 1'b1;
  assign in_ready         = !out_valid_r || out_ready;
  assign in_fire          = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_header_found = out_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_name_r  <= '0;
      exp_value_r <= '0;
      name_len_r  <= 5'd0;
      value_len_r <= 5'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NAME_LOW: begin
          for (int i = 0; i < NAME_BYTES; i++) begin
            if (i < 8) exp_name_r[i] <= cfg_data[8*(i%8) +: 8];
          end
        end
        CFG_NAME_HIGH: begin
          for (int i = 0; i < NAME_BYTES; i++) begin
            if (i >= 8) exp_name_r[i] <= cfg_data[8*(i%8) +: 8];
          end
        end
        CFG_NAME_LEN: name_len_r <= cfg_data[4:0];
        CFG_VALUE_LOW: begin
          for (int i = 0; i < VALUE_STR_BYTES; i++) begin
            if (i < 8) exp_value_r[i] <= cfg_data[8*(i%8) +: 8];
          end
        end
        CFG_VALUE_HIGH: begin
          for (int i = 0; i < VALUE_STR_BYTES; i++) begin
            if (i >= 8) exp_value_r[i] <= cfg_data[8*(i%8) +: 8];
          end
        end
        CFG_VALUE_LEN: value_len_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    name_pad  = '0;
    value_pad = '0;
    for (int k = 0; k < NAME_BYTES; k++) name_pad[k] = exp_name_r[k];
    for (int k = 0; k < VALUE_STR_BYTES; k++) value_pad[k] = exp_value_r[k];
  end

  // One comparison unit serves the name part and the value part in turn.
  assign sel_name  = (phase_r == PH_NAME);
  assign sel_len   = sel_name ? name_len_r : value_len_r;
  assign sel_limit = sel_name ? NAME_LIM : VALUE_LIM;
  assign sel_str   = sel_name ? name_pad : value_pad;

  hlfm_part_unit u_part (
    .data_byte (in_header_byte),
    .cur       (part_r),
    .len       (sel_len),
    .limit     (sel_limit),
    .fold      (sel_name),
    .exp_str   (sel_str),
    .nxt       (part_step)
  );

  always_comb begin
    ph1    = phase_r;
    nm1    = nm_r;
    part1  = part_r;
    found1 = found_r;
    if (in_header_byte == CH_LF) begin
      if ((phase_r != PH_NAME) && nm_r && part_match(part_r, value_len_r, VALUE_LIM)) begin
        found1 = 1'b1;
      end
      ph1   = PH_NAME;
      nm1   = 1'b0;
      part1 = PART_CLEAR;
    end else if (phase_r == PH_NAME) begin
      if (in_header_byte == CH_COLON) begin
        nm1   = part_match(part_r, name_len_r, NAME_LIM);
        part1 = PART_CLEAR;
        ph1   = PH_LEAD;
      end else begin
        part1 = part_step;
      end
    end else if ((phase_r == PH_LEAD) &&
                 ((in_header_byte == CH_SP) || (in_header_byte == CH_TAB))) begin
      // Leading blanks of the value are skipped.
    end else begin
      ph1   = PH_VALUE;
      part1 = part_step;
    end

    // The flagged word also closes the final line unless it is itself an LF.
    last_hit = found1 || ((in_header_byte != CH_LF) && (ph1 != PH_NAME) && nm1 &&
                          part_match(part1, value_len_r, VALUE_LIM));

    phase_nxt = phase_r;
    nm_nxt    = nm_r;
    part_nxt  = part_r;
    found_nxt = found_r;
    if (in_fire) begin
      if (in_end_of_block) begin
        phase_nxt = PH_NAME;
        nm_nxt    = 1'b0;
        part_nxt  = PART_CLEAR;
        found_nxt = 1'b0;
      end else begin
        phase_nxt = ph1;
        nm_nxt    = nm1;
        part_nxt  = part1;
        found_nxt = found1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_NAME;
      nm_r        <= 1'b0;
      part_r      <= PART_CLEAR;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      nm_r    <= nm_nxt;
      part_r  <= part_nxt;
      found_r <= found_nxt;
      if (in_fire && in_end_of_block) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_end_of_block) begin
      out_found_r <= last_hit;
    end
  end

  `ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_fire && in_end_of_block, out_valid)
  `ASSERT_NEXT(a_last_clears_block, clk, rst_n, in_fire && in_end_of_block, (phase_r == PH_NAME) && !found_r && !nm_r && (part_r.pos == 5'd0))
  `ASSERT_SAME(a_name_flag_phase, clk, rst_n, nm_r, phase_r != PH_NAME)
  `ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !in_ready, out_valid_r && !out_ready)
  `ASSERT_NEXT(a_idle_holds_state, clk, rst_n, !in_fire, $stable(phase_r) && $stable(found_r) && $stable(part_r))

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the header line field matcher against a predictor.
module testbench;
  import hlfm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 136;
  // String sizes of the instance under test.
  localparam int STR_LIMIT = 16;
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0] hbyte;
    logic       eob;
  } hdr_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_header_byte = '0;
  logic        in_end_of_block = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_header_found;

  header_line_field_matcher DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor: register copies and line state.
  byte_str_t   want_name, want_value;
  logic [4:0]  want_name_len, want_value_len;
  phase_t      line_part;
  part_state_t part;
  logic        name_hit, block_hit;
  logic        found_due[$];

  // Stimulus side.
  hdr_word_t   bytes_to_send[$];
  logic [7:0]  line_buf[$];
  logic [7:0]  block_buf[$];
  byte_str_t   gen_name, gen_value;
  int          gen_name_len, gen_value_len;
  int          words_sent = 0;
  int          words_taken = 0;
  int          send_odds = 0, take_odds = 0;
  int          send_hold = 0, take_hold = 0;
  logic        in_taken = 1'b0;
  int          cycle_count = 0;
  int          blocks_checked = 0;
  int          errors = 0;

  function automatic logic blank_char(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR);
  endfunction

  function automatic logic letter_char(input logic [7:0] b);
    return ((b | 8'h20) >= 8'h61) && ((b | 8'h20) <= 8'h7A);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("mismatch: %s", what);
  endtask

  task automatic clear_part_state();
    part = '{pos: 5'd0, prefix_mismatch: 1'b0, tail_not_blank: 1'b0, boundary_blank: 1'b0};
  endtask

  task automatic clear_predictor();
    want_name = '0;
    want_value = '0;
    want_name_len = '0;
    want_value_len = '0;
    line_part = PH_NAME;
    name_hit = 1'b0;
    block_hit = 1'b0;
    clear_part_state();
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [63:0] data);
    case (idx)
      CFG_NAME_LOW:   want_name[7:0] = data;
      CFG_NAME_HIGH:  want_name[15:8] = data;
      CFG_NAME_LEN:   want_name_len = data[4:0];
      CFG_VALUE_LOW:  want_value[7:0] = data;
      CFG_VALUE_HIGH: want_value[15:8] = data;
      CFG_VALUE_LEN:  want_value_len = data[4:0];
      default: begin
        // Spare indexes have no register behind them.
      end
    endcase
  endtask

  function automatic logic part_ok(input part_state_t st, input logic [4:0] len);
    if (int'(len) > STR_LIMIT) return 1'b0;
    if ((st.pos < len) || st.prefix_mismatch || st.tail_not_blank) return 1'b0;
    return (len == 5'd0) || !st.boundary_blank;
  endfunction

  task automatic feed_part(input logic [7:0] b, input byte_str_t str, input logic [4:0] len,
                           input logic fold);
    logic [7:0] want, got;
    if (part.pos < len) begin
      if (part.pos < 5'd16) begin
        want = fold ? to_lower(str[part.pos[3:0]]) : str[part.pos[3:0]];
        got = fold ? to_lower(b) : b;
        if (got != want) part.prefix_mismatch = 1'b1;
      end else begin
        part.prefix_mismatch = 1'b1;
      end
      if (int'(part.pos) + 1 == int'(len)) part.boundary_blank = blank_char(b);
    end else if (!blank_char(b)) begin
      part.tail_not_blank = 1'b1;
    end
    if (part.pos != 5'd31) part.pos = part.pos + 5'd1;
  endtask

  task automatic close_line();
    if (line_part != PH_NAME && name_hit && part_ok(part, want_value_len)) block_hit = 1'b1;
    line_part = PH_NAME;
    name_hit = 1'b0;
    clear_part_state();
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    if (b == CH_LF) begin
      close_line();
    end else if (line_part == PH_NAME) begin
      if (b == CH_COLON) begin
        name_hit = part_ok(part, want_name_len);
        clear_part_state();
        line_part = PH_LEAD;
      end else begin
        feed_part(b, want_name, want_name_len, 1'b1);
      end
    end else if (!(line_part == PH_LEAD && (b == CH_SP || b == CH_TAB))) begin
      line_part = PH_VALUE;
      feed_part(b, want_value, want_value_len, 1'b0);
    end
    if (last) begin
      // A flagged LF has already closed its line.
      if (b != CH_LF) close_line();
      found_due.push_back(block_hit);
      block_hit = 1'b0;
      line_part = PH_NAME;
      name_hit = 1'b0;
      clear_part_state();
    end
  endtask

  function automatic logic [7:0] text_byte(input logic for_name);
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: b = 8'h61 + 8'($urandom_range(0, 25));
      1: b = 8'h41 + 8'($urandom_range(0, 25));
      2: b = 8'h21 + 8'($urandom_range(0, 93));
      3: b = 8'($urandom_range(0, 255));
      4: b = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      default: b = 8'h30 + 8'($urandom_range(0, 9));
    endcase
    if (b == CH_LF) b = 8'h7A;
    if (for_name && b == CH_COLON) b = 8'h5F;
    return b;
  endfunction

  function automatic logic [7:0] blank_pick(input logic with_cr);
    case ($urandom_range(0, with_cr ? 2 : 1))
      0: return CH_SP;
      1: return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic int rand_len();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
  endfunction

  task automatic push_word(input logic [7:0] b, input logic last);
    bytes_to_send.push_back('{hbyte: b, eob: last});
    words_sent++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_strings();
    logic [63:0] junk;
    write_reg(CFG_NAME_LOW, gen_name[7:0]);
    write_reg(CFG_NAME_HIGH, gen_name[15:8]);
    // Upper bits of a length word are noise that the register drops.
    junk = {$urandom, $urandom};
    junk[4:0] = 5'(gen_name_len);
    write_reg(CFG_NAME_LEN, junk);
    write_reg(CFG_VALUE_LOW, gen_value[7:0]);
    write_reg(CFG_VALUE_HIGH, gen_value[15:8]);
    junk = {$urandom, $urandom};
    junk[4:0] = 5'(gen_value_len);
    write_reg(CFG_VALUE_LEN, junk);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
  endtask

  task automatic pick_strings(input int k);
    int i;
    for (i = 0; i < STR_BYTES; i++) begin
      gen_name[i] = text_byte(1'b1);
      gen_value[i] = text_byte(1'b0);
    end
    if (k == 5) begin
      gen_name = '1;
      gen_value = '0;
    end
    if (k == 6) begin
      gen_name = '0;
      gen_value = '1;
    end
    case (k)
      0: begin gen_name_len = 0;  gen_value_len = 16; end
      1: begin gen_name_len = 16; gen_value_len = 0; end
      2: begin gen_name_len = 17; gen_value_len = 16; end
      3: begin gen_name_len = 31; gen_value_len = rand_len(); end
      4: begin gen_name_len = rand_len(); gen_value_len = 17; end
      default: begin gen_name_len = rand_len(); gen_value_len = rand_len(); end
    endcase
  endtask

  // A line built from the configured strings, with the name case and the blank padding varied.
  task automatic good_line();
    int i, n;
    logic [7:0] b;
    for (i = 0; i < gen_name_len; i++) begin
      b = (i < STR_BYTES) ? gen_name[i] : text_byte(1'b1);
      if (letter_char(b) && $urandom_range(0, 1)) b = b ^ 8'h20;
      line_buf.push_back(b);
    end
    n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
    for (i = 0; i < n; i++) line_buf.push_back(blank_pick(1'b1));
    line_buf.push_back(CH_COLON);
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) line_buf.push_back(blank_pick(1'b0));
    for (i = 0; i < gen_value_len; i++)
      line_buf.push_back((i < STR_BYTES) ? gen_value[i] : text_byte(1'b0));
    n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
    for (i = 0; i < n; i++) line_buf.push_back(blank_pick(1'b1));
  endtask

  task automatic build_block(output int count);
    int lines, l, i, n, kind, pos;
    block_buf.delete();
    lines = $urandom_range(1, 3);
    for (l = 0; l < lines; l++) begin
      line_buf.delete();
      kind = $urandom_range(0, 19);
      if (kind <= 13) begin
        good_line();
        if (kind >= 9 && line_buf.size() > 0) begin
          pos = $urandom_range(0, line_buf.size() - 1);
          case ($urandom_range(0, 3))
            0: line_buf[pos] = 8'($urandom_range(0, 255));
            1: line_buf.delete(pos);
            2: line_buf.insert(pos, text_byte(1'b0));
            default: line_buf[pos] = line_buf[pos] ^ 8'h20;
          endcase
        end
      end else if (kind <= 15) begin
        n = $urandom_range(0, 20);
        for (i = 0; i < n; i++) line_buf.push_back(text_byte(1'b1));
      end else if (kind <= 17) begin
        n = $urandom_range(0, 12);
        for (i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 19) begin
        line_buf.push_back(CH_COLON);
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) line_buf.push_back(blank_pick(1'b1));
      end
      line_buf.push_back(CH_LF);
      foreach (line_buf[i]) block_buf.push_back(line_buf[i]);
    end
    // The block ends on its LF, on the last text byte, or on one extra byte.
    case ($urandom_range(0, 3))
      0: begin end
      3: block_buf.push_back(8'($urandom_range(0, 255)));
      default: if (block_buf.size() > 1) void'(block_buf.pop_back());
    endcase
    foreach (block_buf[i]) push_word(block_buf[i], i == block_buf.size() - 1);
    count = block_buf.size();
  endtask

  task automatic drain();
    while (words_taken != words_sent || found_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin : drive_words
    hdr_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (send_hold > 0) begin
          in_valid <= 1'b0;
          send_hold--;
        end else if (bytes_to_send.size() > 0) begin
          w = bytes_to_send.pop_front();
          in_valid <= 1'b1;
          in_header_byte <= w.hbyte;
          in_end_of_block <= w.eob;
          if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
            send_hold = $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (take_hold > 0) begin
        out_ready <= 1'b0;
        take_hold--;
      end else begin
        out_ready <= 1'b1;
        if (take_odds != 0 && $urandom_range(1, take_odds) == 1)
          take_hold = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk) begin : watch_words
    logic want_found;
    if (!rst_n) begin
      clear_predictor();
      in_taken = 1'b0;
    end else begin
      cycle_count++;
      in_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        blocks_checked++;
        if (found_due.size() == 0) begin
          report_mismatch($sformatf("result %0b with no block waiting (result %0d)",
                                    out_header_found, blocks_checked));
        end else begin
          want_found = found_due.pop_front();
          if (out_header_found !== want_found)
            report_mismatch($sformatf("block %0d: header_found %0b, predicted %0b",
                                      blocks_checked, out_header_found, want_found));
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_taken) begin
        words_taken++;
        scan_byte(in_header_byte, in_end_of_block);
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int k, sent, n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed blocks, first with the registers as reset leaves them.
    send_odds = 3;
    take_odds = 3;
    @(posedge clk);
    push_word(CH_COLON, 1'b1);
    push_word("a", 1'b1);
    push_word(CH_SP, 1'b0);
    push_word(CH_COLON, 1'b0);
    push_word(CH_TAB, 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(CH_LF, 1'b1);
    push_word(8'hFF, 1'b1);
    drain();
    gen_name = '0;
    gen_value = '0;
    gen_name[3:0] = "dI-x";
    gen_value[2:0] = "b:a";
    gen_name_len = 4;
    gen_value_len = 3;
    load_strings();
    @(posedge clk);
    // Folded name, padding on both sides of the colon, a second colon in the value,
    // then a flagged zero byte that opens a line without a colon.
    push_text("X-iD :  a:b");
    push_word(CH_CR, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word(8'h00, 1'b1);

    for (k = 0; k < PHASES; k++) begin
      drain();
      pick_strings(k);
      load_strings();
      if (k == PHASES - 1) begin
        send_odds = 0;
        take_odds = 0;
      end else begin
        send_odds = (k % 3 == 0) ? 0 : (k % 3 == 1) ? 8 : 2;
        take_odds = (k % 3 == 2) ? 0 : (k % 3 == 0) ? 2 : 6;
      end
      @(posedge clk);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        build_block(n);
        sent += n;
      end
    end
    drain();
    repeat (10) @(negedge clk);
    if (found_due.size() != 0)
      report_mismatch($sformatf("%0d block results never arrived", found_due.size()));
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
